@@ hw/rtl/pva_pkg.sv @@
`default_nettype none

package pva_pkg;

    localparam int COORD_W          = 16;
    localparam int SUM_W            = 41;
    localparam int LO_W             = 21;
    localparam int HI_W             = SUM_W - LO_W;
    localparam int MUL_W            = LO_W + 1;
    localparam int PROD_W           = 2 * MUL_W;
    localparam int NORM_W           = 2 * SUM_W;
    localparam int ROOT_W           = SUM_W;
    localparam int REM_W            = ROOT_W + 3;
    localparam int AREA_W           = 40;
    localparam int CNT_OUT_W        = 9;
    localparam int CNT_OUT_MAX      = 511;
    localparam int MAX_VERTICES_DEF = 256;

    // sequencer step counts: cross issues six products, square issues nine
    localparam int STEP_W      = 4;
    localparam int CROSS_DRAIN = 6;
    localparam int SQ_DRAIN    = 9;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
        logic                      point_valid;
        logic                      last_vertex;
    } item_t;

    typedef struct packed {
        logic [AREA_W-1:0]    area_half_mm2;
        logic [CNT_OUT_W-1:0] vertex_count;
    } result_t;

    typedef struct packed {
        logic              take;
        logic              mul_go;
        logic              mul_sq;
        logic              bsel_first;
        logic [STEP_W-1:0] step;
        logic              prev_load;
        logic              abs_go;
        logic              root_go;
        logic              emit;
        logic              emit_root;
    } cmd_t;

    typedef struct packed {
        logic cnt_zero;
        logic cnt_full;
        logic cnt_ge3;
        logic root_done;
    } sts_t;

endpackage

`default_nettype wire

@@ hw/rtl/polygon_vector_area.sv @@
// channel   ports                      beat taken when
// -------   ------------------------   ------------------------------
// vertex    start, busy, item          start high while busy is low
// result    done, result               done high (one cycle, no hold-off)
//
// an invalid or untaken non-last vertex, or a non-last first vertex, leaves busy low
// any other vertex holds busy while six products go through one shared
// 22x22 multiplier plus drain
// a last vertex, with at least three counted, adds the closing cross product,
// nine partial squares on the same multiplier and a 41-step root before done
// reset clears counts and sums; results cannot be stalled, done is a single-cycle pulse
`default_nettype none

module polygon_vector_area #(
    parameter int MAX_VERTICES = pva_pkg::MAX_VERTICES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  pva_pkg::item_t   item,
    output logic             busy,
    output logic             done,
    output pva_pkg::result_t result
);
    import pva_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pva_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .point_valid (item.point_valid),
        .last_vertex (item.last_vertex),
        .sts         (sts),
        .cmd         (cmd),
        .busy        (busy)
    );

    pva_dp #(
        .MAX_VERTICES (MAX_VERTICES)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .cmd    (cmd),
        .sts    (sts),
        .result (result),
        .done   (done)
    );

    // a result beat only appears once the sequencer is back in idle
    property p_done_idle;
        @(posedge clk) disable iff (!rst_n)
        done |-> !busy;
    endproperty
    a_done_idle: assert property (p_done_idle)
        else $error("result beat while sequencer busy");

    // an ignored, non-closing vertex must not start any work
    property p_skip_idle;
        @(posedge clk) disable iff (!rst_n)
        (start && !busy && !item.point_valid && !item.last_vertex) |=> !busy;
    endproperty
    a_skip_idle: assert property (p_skip_idle)
        else $error("ignored vertex started work");

    // a nonzero area needs at least three vertices
    property p_area_count;
        @(posedge clk) disable iff (!rst_n)
        (done && (result.area_half_mm2 != '0)) |->
            (result.vertex_count >= CNT_OUT_W'(3));
    endproperty
    a_area_count: assert property (p_area_count)
        else $error("nonzero area with fewer than three vertices");

endmodule

`default_nettype wire

@@ hw/rtl/pva_root.sv @@
`default_nettype none

module pva_root (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      go,
    input  logic [pva_pkg::NORM_W-1:0] radicand,
    output logic                      done,
    output logic [pva_pkg::ROOT_W-1:0] root
);
    import pva_pkg::*;

    localparam int CNT_W = $clog2(ROOT_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [NORM_W-1:0] rad_reg;
    logic [REM_W-1:0]  rem_reg;
    logic [ROOT_W-1:0] root_reg;

    logic [REM_W-1:0]  rem_sh;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_next;
    logic [ROOT_W-1:0] root_next;

    // one result bit per cycle, two radicand bits shifted in
    always_comb
    begin
        rem_sh = {rem_reg[REM_W-3:0], rad_reg[NORM_W-1 -: 2]};
        trial  = REM_W'({root_reg, 2'b01});
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[ROOT_W-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (go)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CNT_W'(ROOT_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg  <= {rad_reg[NORM_W-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pva_dp.sv @@
`default_nettype none

module pva_dp #(
    parameter int MAX_VERTICES = pva_pkg::MAX_VERTICES_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  pva_pkg::item_t   item,
    input  pva_pkg::cmd_t    cmd,
    output pva_pkg::sts_t    sts,
    output pva_pkg::result_t result,
    output logic             done
);
    import pva_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam int CMP_W = (CNT_W > CNT_OUT_W) ? CNT_W : CNT_OUT_W;

    localparam logic [1:0] PART_LL = 2'd0;
    localparam logic [1:0] PART_HL = 2'd1;
    localparam logic [1:0] PART_HH = 2'd2;

    logic [CNT_W-1:0]          count_reg;
    logic signed [COORD_W-1:0] first_reg [3];
    logic signed [COORD_W-1:0] prev_reg [3];
    logic signed [COORD_W-1:0] cur_reg [3];
    logic signed [COORD_W-1:0] vin [3];
    logic [SUM_W-1:0]          sum_reg [3];
    logic [NORM_W-1:0]         norm_reg;

    logic [PROD_W-1:0] prod_reg;
    logic [1:0]        pk_reg;
    logic [1:0]        pj_reg;
    logic              pneg_reg;
    logic              psq_reg;
    logic              pvld_reg;

    logic [1:0]               ia;
    logic [1:0]               ib;
    logic [1:0]               mk;
    logic [1:0]               mj;
    logic                     mneg;
    logic signed [COORD_W-1:0] va;
    logic signed [COORD_W-1:0] vb;
    logic [MUL_W-1:0]         lo_op;
    logic [MUL_W-1:0]         hi_op;
    logic signed [MUL_W-1:0]  op_a;
    logic signed [MUL_W-1:0]  op_b;
    logic signed [PROD_W-1:0] prod;
    logic [NORM_W-1:0]        prod_sh;

    logic              root_done;
    logic [ROOT_W-1:0] root_val;
    logic [CMP_W-1:0]  cnt_wide;
    logic [CNT_OUT_W-1:0] cnt_sat;
    logic [AREA_W-1:0] area_sat;

    result_t result_reg;
    logic    done_reg;

    assign vin[0] = item.vertex_x;
    assign vin[1] = item.vertex_y;
    assign vin[2] = item.vertex_z;

    // product schedule: c0 = a1*b2 - a2*b1, c1 = a2*b0 - a0*b2, c2 = a0*b1 - a1*b0
    always_comb
    begin
        ia   = 2'd0;
        ib   = 2'd0;
        mk   = 2'd0;
        mj   = PART_LL;
        mneg = 1'b0;
        if (!cmd.mul_sq)
        begin
            case (cmd.step)
                'd0:     begin ia = 2'd1; ib = 2'd2; mk = 2'd0; mneg = 1'b0; end
                'd1:     begin ia = 2'd2; ib = 2'd1; mk = 2'd0; mneg = 1'b1; end
                'd2:     begin ia = 2'd2; ib = 2'd0; mk = 2'd1; mneg = 1'b0; end
                'd3:     begin ia = 2'd0; ib = 2'd2; mk = 2'd1; mneg = 1'b1; end
                'd4:     begin ia = 2'd0; ib = 2'd1; mk = 2'd2; mneg = 1'b0; end
                'd5:     begin ia = 2'd1; ib = 2'd0; mk = 2'd2; mneg = 1'b1; end
                default: begin ia = 2'd0; ib = 2'd0; mk = 2'd0; mneg = 1'b0; end
            endcase
        end
        else
        begin
            case (cmd.step)
                'd0:     begin mk = 2'd0; mj = PART_LL; end
                'd1:     begin mk = 2'd0; mj = PART_HL; end
                'd2:     begin mk = 2'd0; mj = PART_HH; end
                'd3:     begin mk = 2'd1; mj = PART_LL; end
                'd4:     begin mk = 2'd1; mj = PART_HL; end
                'd5:     begin mk = 2'd1; mj = PART_HH; end
                'd6:     begin mk = 2'd2; mj = PART_LL; end
                'd7:     begin mk = 2'd2; mj = PART_HL; end
                'd8:     begin mk = 2'd2; mj = PART_HH; end
                default: begin mk = 2'd0; mj = PART_LL; end
            endcase
        end
    end

    always_comb
    begin
        va    = prev_reg[ia];
        vb    = cmd.bsel_first ? first_reg[ib] : cur_reg[ib];
        lo_op = {1'b0, sum_reg[mk][LO_W-1:0]};
        hi_op = {{(MUL_W-HI_W){1'b0}}, sum_reg[mk][SUM_W-1:LO_W]};
        if (!cmd.mul_sq)
        begin
            op_a = {{(MUL_W-COORD_W){va[COORD_W-1]}}, va};
            op_b = {{(MUL_W-COORD_W){vb[COORD_W-1]}}, vb};
        end
        else
        begin
            case (mj)
                PART_LL: begin op_a = lo_op; op_b = lo_op; end
                PART_HL: begin op_a = hi_op; op_b = lo_op; end
                default: begin op_a = hi_op; op_b = hi_op; end
            endcase
        end
    end

    assign prod = op_a * op_b;

    always_comb
    begin
        case (pj_reg)
            PART_LL: prod_sh = NORM_W'(prod_reg);
            PART_HL: prod_sh = NORM_W'(prod_reg) << (LO_W + 1);
            default: prod_sh = NORM_W'(prod_reg) << (2 * LO_W);
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pvld_reg <= 1'b0;
        end
        else
        begin
            pvld_reg <= cmd.mul_go;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mul_go)
        begin
            prod_reg <= prod;
            pk_reg   <= mk;
            pj_reg   <= mj;
            pneg_reg <= mneg;
            psq_reg  <= cmd.mul_sq;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else if (cmd.emit)
        begin
            count_reg <= '0;
            for (int k = 0; k < 3; k++)
            begin
                sum_reg[k] <= '0;
            end
        end
        else
        begin
            if (cmd.take)
            begin
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.abs_go)
            begin
                // magnitudes in place, read as unsigned from here on
                for (int k = 0; k < 3; k++)
                begin
                    if (sum_reg[k][SUM_W-1])
                    begin
                        sum_reg[k] <= -sum_reg[k];
                    end
                end
            end
            else if (pvld_reg && !psq_reg)
            begin
                if (pneg_reg)
                begin
                    sum_reg[pk_reg] <= sum_reg[pk_reg] - prod_reg[SUM_W-1:0];
                end
                else
                begin
                    sum_reg[pk_reg] <= sum_reg[pk_reg] + prod_reg[SUM_W-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.abs_go)
        begin
            norm_reg <= '0;
        end
        else if (pvld_reg && psq_reg)
        begin
            norm_reg <= norm_reg + prod_sh;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take)
        begin
            for (int k = 0; k < 3; k++)
            begin
                cur_reg[k] <= vin[k];
            end
            if (count_reg == '0)
            begin
                for (int k = 0; k < 3; k++)
                begin
                    first_reg[k] <= vin[k];
                    prev_reg[k]  <= vin[k];
                end
            end
        end
        else if (cmd.prev_load)
        begin
            for (int k = 0; k < 3; k++)
            begin
                prev_reg[k] <= cur_reg[k];
            end
        end
    end

    pva_root u_root (
        .clk      (clk),
        .rst_n    (rst_n),
        .go       (cmd.root_go),
        .radicand (norm_reg),
        .done     (root_done),
        .root     (root_val)
    );

    always_comb
    begin
        cnt_wide = CMP_W'(count_reg);
        if (cnt_wide > CMP_W'(CNT_OUT_MAX))
        begin
            cnt_sat = CNT_OUT_W'(CNT_OUT_MAX);
        end
        else
        begin
            cnt_sat = cnt_wide[CNT_OUT_W-1:0];
        end
        area_sat = (|root_val[ROOT_W-1:AREA_W]) ? '1 : root_val[AREA_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            result_reg.area_half_mm2 <= cmd.emit_root ? area_sat : '0;
            result_reg.vertex_count  <= cnt_sat;
        end
    end

    always_comb
    begin
        sts.cnt_zero  = (count_reg == '0);
        sts.cnt_full  = (count_reg == CNT_W'(MAX_VERTICES));
        sts.cnt_ge3   = (count_reg >= CNT_W'(3));
        sts.root_done = root_done;
    end

    assign result = result_reg;
    assign done   = done_reg;

endmodule

`default_nettype wire

@@ hw/rtl/pva_ctrl.sv @@
`default_nettype none

module pva_ctrl (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic          point_valid,
    input  logic          last_vertex,
    input  pva_pkg::sts_t sts,
    output pva_pkg::cmd_t cmd,
    output logic          busy
);
    import pva_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CROSS,
        S_CHECK,
        S_ABS,
        S_SQUARE,
        S_ROOT
    } state_t;

    state_t            state_reg;
    state_t            state_next;
    logic [STEP_W-1:0] step_reg;
    logic [STEP_W-1:0] step_next;
    logic              last_reg;
    logic              last_next;
    logic              close_reg;
    logic              close_next;
    logic              busy_reg;
    logic              busy_next;
    logic              take;

    assign take = point_valid && !sts.cnt_full;

    always_comb
    begin
        state_next     = state_reg;
        step_next      = step_reg;
        last_next      = last_reg;
        close_next     = close_reg;
        cmd            = '0;
        cmd.step       = step_reg;
        cmd.bsel_first = close_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    last_next  = last_vertex;
                    close_next = 1'b0;
                    cmd.take   = take;
                    if (take && !sts.cnt_zero)
                    begin
                        step_next  = '0;
                        state_next = S_CROSS;
                    end
                    else if (last_vertex)
                    begin
                        state_next = S_CHECK;
                    end
                end
            end
            S_CROSS:
            begin
                if (step_reg < STEP_W'(CROSS_DRAIN))
                begin
                    cmd.mul_go = 1'b1;
                    step_next  = step_reg + 1'b1;
                end
                else if (close_reg)
                begin
                    state_next = S_ABS;
                end
                else
                begin
                    cmd.prev_load = 1'b1;
                    state_next    = last_reg ? S_CHECK : S_IDLE;
                end
            end
            S_CHECK:
            begin
                if (sts.cnt_ge3)
                begin
                    // closing edge: last vertex back to first
                    close_next = 1'b1;
                    step_next  = '0;
                    state_next = S_CROSS;
                end
                else
                begin
                    cmd.emit   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_ABS:
            begin
                cmd.abs_go = 1'b1;
                step_next  = '0;
                state_next = S_SQUARE;
            end
            S_SQUARE:
            begin
                cmd.mul_sq = 1'b1;
                if (step_reg < STEP_W'(SQ_DRAIN))
                begin
                    cmd.mul_go = 1'b1;
                    step_next  = step_reg + 1'b1;
                end
                else if (step_reg == STEP_W'(SQ_DRAIN))
                begin
                    // last partial product lands this cycle
                    step_next = step_reg + 1'b1;
                end
                else
                begin
                    cmd.root_go = 1'b1;
                    state_next  = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (sts.root_done)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_root = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
        busy_next = (state_next != S_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            step_reg  <= '0;
            last_reg  <= 1'b0;
            close_reg <= 1'b0;
            busy_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            last_reg  <= last_next;
            close_reg <= close_next;
            busy_reg  <= busy_next;
        end
    end

    assign busy = busy_reg;

endmodule

`default_nettype wire
